// ----- rtl/core/pstr_pkg.sv -----
// Shared types and codes for the pixel store transform reader.
`timescale 1ns / 1ps

package pstr_pkg;

    // Field widths
    localparam int COORD_W     = 10;
    localparam int DIM_W       = 9;
    localparam int COLOR_W     = 32;
    localparam int PROD_W      = 2 * DIM_W;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_AW      = 5;

    typedef logic [DIM_W-1:0] dim_t;

    // Register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_SRC_WIDTH    = 3'd0;
    localparam logic [2:0] REG_SRC_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_VIEW_MODE    = 3'd2;
    localparam logic [2:0] REG_SCALE_WIDTH  = 3'd3;
    localparam logic [2:0] REG_SCALE_HEIGHT = 3'd4;

    // View codes
    localparam logic [2:0] VIEW_IDENT   = 3'd0;
    localparam logic [2:0] VIEW_FLIP_H  = 3'd1;
    localparam logic [2:0] VIEW_FLIP_V  = 3'd2;
    localparam logic [2:0] VIEW_ROT_CW  = 3'd3;
    localparam logic [2:0] VIEW_ROT_CCW = 3'd4;
    localparam logic [2:0] VIEW_ROT_180 = 3'd5;
    localparam logic [2:0] VIEW_SCALE   = 3'd6;

    // Item actions
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

endpackage

// ----- rtl/core/pixel_store_transform_reader_top.sv -----
// Pixel store with rotate, flip and nearest-neighbor scale read-out.
//
// Usage: items enter on the s_axis channel. tuser[0] selects the action: a write
// stores tdata color at source (x,y), a read fetches the pixel seen at output (x,y)
// through the view set in the APB registers. Every item gives one result on the
// m_axis channel: the pixel in tdata and the in-bounds flag in tuser.
// Reset: after rst_n rises, a clearing pass zeroes the store, one word a cycle,
// through all MAX_WIDTH*MAX_HEIGHT words (65536 at the default size); s_axis_tready
// stays low meanwhile, while register writes are taken as usual.
// Timing: one item at a time. An out-of-bounds item, or a scale-mode read of an
// empty source, goes from S_CALC to S_FIN; an in-bounds write or non-scale read
// passes S_CALC, S_ADDR, S_MEM, S_FIN; any other scale-mode read adds S_MULX, S_DIVX,
// S_MULY, S_DIVY before S_ADDR. The next item is taken in S_IDLE after the result is
// loaded. Scale reads go through the shared restoring divider, 9 steps per division,
// run once for the column and once for the row, with one shared 9x9 multiplier feeding it.
// Stall: a finished result waits in the output register while the next item is
// taken; a further result holds in its final state until m_axis_tready frees it.
`timescale 1ns / 1ps

module pixel_store_transform_reader_top #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input item stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [pstr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // x[9:0], y[19:10], color[51:20]
    input  logic [0:0]                          s_axis_tuser,   // action[0]
    // Result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [pstr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // pixel[31:0]
    output logic [0:0]                          m_axis_tuser,   // in_bounds[0]
    // Register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pstr_pkg::CFG_AW-1:0]         paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    import pstr_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Sequencer states
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CALC  = 4'd2;
    localparam logic [3:0] S_MULX  = 4'd3;
    localparam logic [3:0] S_DIVX  = 4'd4;
    localparam logic [3:0] S_MULY  = 4'd5;
    localparam logic [3:0] S_DIVY  = 4'd6;
    localparam logic [3:0] S_ADDR  = 4'd7;
    localparam logic [3:0] S_MEM   = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    // Configuration registers
    dim_t       src_width_reg;
    dim_t       src_height_reg;
    logic [2:0] view_mode_reg;
    dim_t       scale_width_reg;
    dim_t       scale_height_reg;

    logic       cfg_we;
    logic [2:0] cfg_idx;

    // Control
    logic [3:0]    state_reg, state_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_free;
    logic          div_last;

    // Item payload and work registers
    logic                act_reg;
    logic                x_neg_reg, y_neg_reg;
    dim_t                x_reg, y_reg;
    logic [COLOR_W-1:0]  color_reg;
    dim_t                sx_reg, sy_reg;
    logic                ib_reg;
    logic                rd_hit_reg;
    logic [PROD_W-1:0]   prod_reg;
    dim_t                rem_reg, quo_reg;
    logic [COLOR_W-1:0]  rdata_reg;
    logic [COLOR_W-1:0]  out_pixel_reg;
    logic                out_ib_reg;

    // View geometry
    dim_t  eff_w, eff_h, ow, oh, lim_x, lim_y, sx_calc, sy_calc;
    logic  bound_ok, src_empty;

    // Shared multiplier and divider step
    dim_t              mul_a, mul_b;
    logic [PROD_W-1:0] mul_p;
    dim_t              div_d, div_lim, quo_step, rem_step, quo_clamp;
    logic [DIM_W:0]    div_t, div_r;
    logic              div_ge;

    // Memory
    logic [COLOR_W-1:0] mem [0:DEPTH-1];
    logic [PROD_W-1:0]  addr_sum;
    logic [AW+PROD_W-1:0] addr_ext;
    logic [AW-1:0]      mem_addr;
    logic               mem_we, mem_re;
    logic [COLOR_W-1:0] mem_wdata;

    // ---------------------------------------------------------------
    // Register port
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[CFG_AW-1:2];

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg    <= 9'd256;
            src_height_reg   <= 9'd256;
            view_mode_reg    <= VIEW_IDENT;
            scale_width_reg  <= 9'd1;
            scale_height_reg <= 9'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_SRC_WIDTH:    src_width_reg    <= pwdata[DIM_W-1:0];
                REG_SRC_HEIGHT:   src_height_reg   <= pwdata[DIM_W-1:0];
                REG_VIEW_MODE:    view_mode_reg    <= pwdata[2:0];
                REG_SCALE_WIDTH:  scale_width_reg  <= pwdata[DIM_W-1:0];
                REG_SCALE_HEIGHT: scale_height_reg <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb
    begin
        unique case (cfg_idx)
            REG_SRC_WIDTH:    prdata = {{(32-DIM_W){1'b0}}, src_width_reg};
            REG_SRC_HEIGHT:   prdata = {{(32-DIM_W){1'b0}}, src_height_reg};
            REG_VIEW_MODE:    prdata = {29'd0, view_mode_reg};
            REG_SCALE_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, scale_width_reg};
            REG_SCALE_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, scale_height_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // View geometry
    // ---------------------------------------------------------------
    // Clip the source size to the store dimensions
    assign eff_w = ({{(32-DIM_W){1'b0}}, src_width_reg} > 32'(MAX_WIDTH))
                   ? DIM_W'(MAX_WIDTH) : src_width_reg;
    assign eff_h = ({{(32-DIM_W){1'b0}}, src_height_reg} > 32'(MAX_HEIGHT))
                   ? DIM_W'(MAX_HEIGHT) : src_height_reg;

    // Output image size per view
    always_comb
    begin
        unique case (view_mode_reg) inside
            VIEW_ROT_CW, VIEW_ROT_CCW:
            begin
                ow = eff_h;
                oh = eff_w;
            end
            VIEW_SCALE:
            begin
                ow = (scale_width_reg == '0) ? 9'd1 : scale_width_reg;
                oh = (scale_height_reg == '0) ? 9'd1 : scale_height_reg;
            end
            default:
            begin
                ow = eff_w;
                oh = eff_h;
            end
        endcase
    end

    // Bounds check against the addressed image
    assign lim_x     = (act_reg == ACT_READ) ? ow : eff_w;
    assign lim_y     = (act_reg == ACT_READ) ? oh : eff_h;
    assign bound_ok  = !x_neg_reg && !y_neg_reg && (x_reg < lim_x) && (y_reg < lim_y);
    assign src_empty = (eff_w == '0) || (eff_h == '0);

    // Source coordinate for the fixed views
    always_comb
    begin
        sx_calc = x_reg;
        sy_calc = y_reg;
        if (act_reg == ACT_READ)
        begin
            unique case (view_mode_reg)
                VIEW_FLIP_H:
                begin
                    sx_calc = eff_w - 9'd1 - x_reg;
                end
                VIEW_FLIP_V:
                begin
                    sy_calc = eff_h - 9'd1 - y_reg;
                end
                VIEW_ROT_CW:
                begin
                    sx_calc = y_reg;
                    sy_calc = eff_h - 9'd1 - x_reg;
                end
                VIEW_ROT_CCW:
                begin
                    sx_calc = eff_w - 9'd1 - y_reg;
                    sy_calc = x_reg;
                end
                VIEW_ROT_180:
                begin
                    sx_calc = eff_w - 9'd1 - x_reg;
                    sy_calc = eff_h - 9'd1 - y_reg;
                end
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Shared arithmetic
    // ---------------------------------------------------------------
    // Pick multiplier operands: x*w, y*h, then row*w for the address
    always_comb
    begin
        unique case (state_reg)
            S_MULX:
            begin
                mul_a = x_reg;
                mul_b = eff_w;
            end
            S_MULY:
            begin
                mul_a = y_reg;
                mul_b = eff_h;
            end
            default:
            begin
                mul_a = sy_reg;
                mul_b = eff_w;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // One restoring divider step; quotient fits in DIM_W bits since x < ow
    assign div_d     = (state_reg == S_DIVY) ? oh : ow;
    assign div_lim   = (state_reg == S_DIVY) ? eff_h : eff_w;
    assign div_t     = {rem_reg, quo_reg[DIM_W-1]};
    assign div_ge    = (div_t >= {1'b0, div_d});
    assign div_r     = div_ge ? (div_t - {1'b0, div_d}) : div_t;
    assign rem_step  = div_r[DIM_W-1:0];
    assign quo_step  = {quo_reg[DIM_W-2:0], div_ge};
    assign quo_clamp = (quo_step >= div_lim) ? (div_lim - 9'd1) : quo_step;
    assign div_last  = (cnt_reg == 4'(DIM_W - 1));

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                if (!bound_ok || ((act_reg == ACT_READ) && src_empty))
                begin
                    state_next = S_FIN;
                end
                else if ((act_reg == ACT_READ) && (view_mode_reg == VIEW_SCALE))
                begin
                    state_next = S_MULX;
                end
                else
                begin
                    state_next = S_ADDR;
                end
            end
            S_MULX:
            begin
                cnt_next   = '0;
                state_next = S_DIVX;
            end
            S_DIVX:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (div_last)
                begin
                    state_next = S_MULY;
                end
            end
            S_MULY:
            begin
                cnt_next   = '0;
                state_next = S_DIVY;
            end
            S_DIVY:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (div_last)
                begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                state_next = S_MEM;
            end
            S_MEM:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        // Capture the accepted item
        if ((state_reg == S_IDLE) && s_axis_tvalid)
        begin
            act_reg   <= s_axis_tuser[0];
            x_neg_reg <= s_axis_tdata[COORD_W-1];
            x_reg     <= s_axis_tdata[DIM_W-1:0];
            y_neg_reg <= s_axis_tdata[2*COORD_W-1];
            y_reg     <= s_axis_tdata[COORD_W+DIM_W-1:COORD_W];
            color_reg <= s_axis_tdata[2*COORD_W+COLOR_W-1:2*COORD_W];
        end
        // Check bounds and resolve the fixed views
        if (state_reg == S_CALC)
        begin
            ib_reg     <= bound_ok;
            sx_reg     <= sx_calc;
            sy_reg     <= sy_calc;
            rd_hit_reg <= 1'b0;
        end
        // Load the divider from the product
        if ((state_reg == S_MULX) || (state_reg == S_MULY))
        begin
            rem_reg <= mul_p[PROD_W-1:DIM_W];
            quo_reg <= mul_p[DIM_W-1:0];
        end
        // Step the divider, clamp the final quotient
        if ((state_reg == S_DIVX) || (state_reg == S_DIVY))
        begin
            rem_reg <= rem_step;
            quo_reg <= quo_step;
            if (div_last)
            begin
                if (state_reg == S_DIVX)
                begin
                    sx_reg <= quo_clamp;
                end
                else
                begin
                    sy_reg <= quo_clamp;
                end
            end
        end
        // Row offset
        if (state_reg == S_ADDR)
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == S_MEM)
        begin
            rd_hit_reg <= (act_reg == ACT_READ);
        end
        // Load the result
        if ((state_reg == S_FIN) && out_free)
        begin
            out_pixel_reg <= rd_hit_reg ? rdata_reg : '0;
            out_ib_reg    <= ib_reg;
        end
    end

    // ---------------------------------------------------------------
    // Pixel store
    // ---------------------------------------------------------------
    assign addr_sum  = prod_reg + PROD_W'(sx_reg);
    assign addr_ext  = {{AW{1'b0}}, addr_sum};
    assign mem_addr  = (state_reg == S_CLEAR) ? clr_cnt_reg : addr_ext[AW-1:0];
    assign mem_we    = (state_reg == S_CLEAR) || ((state_reg == S_MEM) && (act_reg == ACT_WRITE));
    assign mem_re    = (state_reg == S_MEM) && (act_reg == ACT_READ);
    assign mem_wdata = (state_reg == S_CLEAR) ? '0 : color_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    // Drive the result stream
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pixel_reg;
    assign m_axis_tuser  = out_ib_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken again right after an item");

    a_div_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DIVX) || (state_reg == S_DIVY)) |-> (rem_reg < div_d))
        else $error("divider remainder not below divisor");

    a_mem_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (32'(mem_addr) < 32'(DEPTH)))
        else $error("store write outside the array");

    a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("out-of-bounds result carries a pixel");

endmodule

// ----- dv/pixel_store_transform_reader_top_tb.sv -----
// Self-checking testbench for the pixel store transform reader.
`timescale 1ns / 1ps

module pixel_store_transform_reader_top_tb;

    import pstr_pkg::*;

    localparam int          MAX_W        = 256;
    localparam int          MAX_H        = 256;
    localparam int          STORE_WORDS  = MAX_W * MAX_H;
    localparam int          ITEM_TARGET  = 1550;
    localparam int          IDLE_LIMIT   = 300000;
    localparam int          LONG_HOLD    = 400;
    localparam int          END_WAIT     = 30;
    // Unused view code, treated as identity
    localparam logic [2:0]  VIEW_UNUSED  = 3'd7;

    typedef struct {
        bit [31:0] pixel;
        bit        in_bounds;
    } pixel_result_t;

    typedef struct {
        bit [8:0] src_w;
        bit [8:0] src_h;
        bit [2:0] view;
        bit [8:0] scl_w;
        bit [8:0] scl_h;
    } view_cfg_t;

    // Mirror of the pixel store and registers; predicts each result in order
    class pixel_view_scoreboard;
        bit [31:0]     store [STORE_WORDS];
        bit [8:0]      src_w = 9'd256;
        bit [8:0]      src_h = 9'd256;
        bit [2:0]      view  = VIEW_IDENT;
        bit [8:0]      scl_w = 9'd1;
        bit [8:0]      scl_h = 9'd1;
        pixel_result_t pending_pixels [$];
        int            errors = 0;

        function void set_reg(logic [2:0] idx, bit [8:0] value);
            case (idx)
                REG_SRC_WIDTH:    src_w = value;
                REG_SRC_HEIGHT:   src_h = value;
                REG_VIEW_MODE:    view  = value[2:0];
                REG_SCALE_WIDTH:  scl_w = value;
                REG_SCALE_HEIGHT: scl_h = value;
                default:          ;
            endcase
        endfunction

        // Source size, clipped to the store
        function void eff_dims(output int unsigned w, output int unsigned h);
            w = (src_w > MAX_W) ? MAX_W : src_w;
            h = (src_h > MAX_H) ? MAX_H : src_h;
        endfunction

        // Size of the image seen through the current view
        function void out_dims(output int unsigned ow, output int unsigned oh);
            int unsigned w, h;
            eff_dims(w, h);
            if (view == VIEW_ROT_CW || view == VIEW_ROT_CCW)
            begin
                ow = h;
                oh = w;
            end
            else if (view == VIEW_SCALE)
            begin
                ow = (scl_w == 0) ? 1 : scl_w;
                oh = (scl_h == 0) ? 1 : scl_h;
            end
            else
            begin
                ow = w;
                oh = h;
            end
        endfunction

        // Note an accepted item; return 1 for every read and for an in-bounds write
        function bit take_item(bit act, bit [9:0] xr, bit [9:0] yr, bit [31:0] color);
            int            xi, yi;
            int unsigned   w, h, ow, oh, sx, sy;
            pixel_result_t res;
            xi = int'($signed(xr));
            yi = int'($signed(yr));
            eff_dims(w, h);
            res.pixel     = 32'h0;
            res.in_bounds = 1'b0;
            if (act == ACT_WRITE)
            begin
                if (xi >= 0 && yi >= 0 && xi < w && yi < h)
                begin
                    store[yi * w + xi] = color;
                    res.in_bounds = 1'b1;
                end
            end
            else
            begin
                out_dims(ow, oh);
                if (xi >= 0 && yi >= 0 && xi < ow && yi < oh)
                begin
                    res.in_bounds = 1'b1;
                    // Empty source reads as zero
                    if (w != 0 && h != 0)
                    begin
                        case (view)
                            VIEW_FLIP_H:
                            begin
                                sx = w - 1 - xi;
                                sy = yi;
                            end
                            VIEW_FLIP_V:
                            begin
                                sx = xi;
                                sy = h - 1 - yi;
                            end
                            VIEW_ROT_CW:
                            begin
                                sx = yi;
                                sy = h - 1 - xi;
                            end
                            VIEW_ROT_CCW:
                            begin
                                sx = w - 1 - yi;
                                sy = xi;
                            end
                            VIEW_ROT_180:
                            begin
                                sx = w - 1 - xi;
                                sy = h - 1 - yi;
                            end
                            VIEW_SCALE:
                            begin
                                sx = (xi * w) / ow;
                                sy = (yi * h) / oh;
                                if (sx >= w) sx = w - 1;
                                if (sy >= h) sy = h - 1;
                            end
                            default:
                            begin
                                sx = xi;
                                sy = yi;
                            end
                        endcase
                        res.pixel = store[sy * w + sx];
                    end
                end
            end
            pending_pixels.push_back(res);
            return (act == ACT_READ) || res.in_bounds;
        endfunction

        // Compare one result with the oldest expectation
        function void check_result(bit [31:0] pixel, bit in_bounds);
            pixel_result_t exp_res;
            if (pending_pixels.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual pixel %h in_bounds %b",
                         $time, pixel, in_bounds);
            end
            else
            begin
                exp_res = pending_pixels.pop_front();
                if (pixel !== exp_res.pixel)
                begin
                    errors++;
                    $display("%0t: pixel mismatch: expected %h, actual %h",
                             $time, exp_res.pixel, pixel);
                end
                if (in_bounds !== exp_res.in_bounds)
                begin
                    errors++;
                    $display("%0t: in_bounds mismatch: expected %b, actual %b",
                             $time, exp_res.in_bounds, in_bounds);
                end
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;   // x[9:0], y[19:10], color[51:20], zero pad
    logic [0:0]              s_axis_tuser;   // action[0]
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;   // pixel[31:0]
    logic [0:0]              m_axis_tuser;   // in_bounds[0]
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [CFG_AW-1:0]       paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;

    pixel_view_scoreboard sb;
    int                   useful_items = 0;
    int                   burst_left   = 0;
    bit                   hold_request = 1'b0;
    int                   idle_cycles  = 0;

    pixel_store_transform_reader_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Check every result taken by the receiver
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser[0]);
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: stall in changing styles, with a long hold-off on request
    initial
    begin
        int style;
        int style_left;
        int hold_left;
        int cyc;
        style         = 0;
        style_left    = 0;
        hold_left     = 0;
        cyc           = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (style_left == 0)
                begin
                    style      = $urandom_range(0, 3);
                    style_left = $urandom_range(16, 96);
                end
                style_left--;
                case (style)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 2) != 0);
                    2:       m_axis_tready <= ((cyc % 5) < 2);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Register write: setup cycle, then access cycle until pready
    task automatic apb_write(logic [2:0] idx, bit [8:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'({idx, 2'b00});
        pwdata  <= {23'h0, value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_cfg(view_cfg_t c);
        apb_write(REG_SRC_WIDTH,    c.src_w);
        apb_write(REG_SRC_HEIGHT,   c.src_h);
        apb_write(REG_VIEW_MODE,    {6'h0, c.view});
        apb_write(REG_SCALE_WIDTH,  c.scl_w);
        apb_write(REG_SCALE_HEIGHT, c.scl_h);
    endtask

    // Offer one item, with a random gap at the start of each burst
    task automatic push_item(bit act, bit [9:0] x, bit [9:0] y, bit [31:0] color);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'h0, color, y, x};
        s_axis_tuser  <= act;
        do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
        if (sb.take_item(act, x, y, color))
            useful_items++;
    endtask

    // Drop valid and wait until every result is back
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic bit [9:0] inside_coord(int unsigned lim);
        if (lim == 0)
            return 10'($urandom);
        return 10'($urandom_range(0, lim - 1));
    endfunction

    // Coordinates on and just past the image border, or random
    function automatic bit [9:0] edge_coord(int unsigned lim);
        case ($urandom_range(0, 3))
            0:       return 10'(lim);
            1:       return 10'h3FF;
            2:       return (lim == 0) ? 10'h0 : 10'(lim - 1);
            default: return 10'($urandom);
        endcase
    endfunction

    // Mostly in-bounds writes and reads under the current view, some noise
    task automatic stream_phase(int n);
        int unsigned w, h, ow, oh;
        int          kind;
        bit          act;
        bit [9:0]    x, y;
        sb.eff_dims(w, h);
        sb.out_dims(ow, oh);
        repeat (n)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                act = ACT_WRITE;
                x   = inside_coord(w);
                y   = inside_coord(h);
            end
            else if (kind < 85)
            begin
                act = ACT_READ;
                x   = inside_coord(ow);
                y   = inside_coord(oh);
            end
            else if (kind < 95)
            begin
                act = 1'($urandom_range(0, 1));
                x   = edge_coord((act == ACT_READ) ? ow : w);
                y   = edge_coord((act == ACT_READ) ? oh : h);
            end
            else
            begin
                act = 1'($urandom_range(0, 1));
                x   = 10'($urandom);
                y   = 10'($urandom);
            end
            push_item(act, x, y, $urandom);
        end
    endtask

    function automatic bit [8:0] pick_src_dim();
        case ($urandom_range(0, 19))
            0:       return 9'd0;
            1:       return 9'd256;
            2:       return 9'($urandom_range(257, 511));
            default: return 9'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic bit [8:0] pick_scale_dim();
        case ($urandom_range(0, 9))
            0:       return 9'd0;
            1:       return 9'd256;
            2:       return 9'd511;
            default: return 9'($urandom_range(1, 16));
        endcase
    endfunction

    initial
    begin
        view_cfg_t fixed_cfgs [10];
        view_cfg_t cfg;
        int        phase;
        sb = new;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;

        // Oversized source, empty sources, zero and full scale sizes, every view
        fixed_cfgs[0] = '{9'd511, 9'd511, VIEW_ROT_CW,  9'd0,   9'd0};
        fixed_cfgs[1] = '{9'd0,   9'd5,   VIEW_SCALE,   9'd0,   9'd0};
        fixed_cfgs[2] = '{9'd0,   9'd0,   VIEW_IDENT,   9'd3,   9'd3};
        fixed_cfgs[3] = '{9'd4,   9'd3,   VIEW_UNUSED,  9'd1,   9'd1};
        fixed_cfgs[4] = '{9'd6,   9'd4,   VIEW_SCALE,   9'd256, 9'd256};
        fixed_cfgs[5] = '{9'd3,   9'd7,   VIEW_FLIP_H,  9'd2,   9'd2};
        fixed_cfgs[6] = '{9'd7,   9'd3,   VIEW_FLIP_V,  9'd5,   9'd9};
        fixed_cfgs[7] = '{9'd5,   9'd6,   VIEW_ROT_CCW, 9'd1,   9'd1};
        fixed_cfgs[8] = '{9'd8,   9'd2,   VIEW_ROT_180, 9'd7,   9'd4};
        fixed_cfgs[9] = '{9'd256, 9'd256, VIEW_SCALE,   9'd511, 9'd511};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset view: corners, borders and far out-of-range coordinates
        push_item(ACT_WRITE, 10'd0,   10'd0,   32'hFFFF_FFFF);
        push_item(ACT_WRITE, 10'd255, 10'd255, 32'h8000_0001);
        push_item(ACT_WRITE, 10'd255, 10'd0,   32'h0000_FFFF);
        push_item(ACT_WRITE, 10'd0,   10'd255, 32'hFFFF_0000);
        push_item(ACT_WRITE, 10'h200, 10'h200, 32'hDEAD_BEEF);  // most negative
        push_item(ACT_WRITE, 10'd511, 10'd511, 32'hA5A5_A5A5);
        push_item(ACT_WRITE, 10'd256, 10'd0,   32'h1234_5678);
        push_item(ACT_WRITE, 10'd0,   10'd256, 32'h8765_4321);
        push_item(ACT_WRITE, 10'h3FF, 10'd5,   32'h5A5A_5A5A);  // x = -1
        push_item(ACT_READ,  10'd0,   10'd0,   32'hFFFF_FFFF);
        push_item(ACT_READ,  10'd255, 10'd255, 32'h0);
        push_item(ACT_READ,  10'd255, 10'd0,   32'h0);
        push_item(ACT_READ,  10'd0,   10'd255, 32'h0);
        push_item(ACT_READ,  10'd256, 10'd255, 32'h0);
        push_item(ACT_READ,  10'h3FF, 10'd0,   32'h0);
        push_item(ACT_READ,  10'd511, 10'h200, 32'h0);
        push_item(ACT_READ,  10'h200, 10'd511, 32'h0);
        push_item(ACT_READ,  10'd17,  10'd33,  32'h0);           // never written
        drain();

        foreach (fixed_cfgs[i])
        begin
            apply_cfg(fixed_cfgs[i]);
            stream_phase(30);
            drain();
        end

        // Random settings until enough items have been through
        phase = 0;
        while (useful_items < ITEM_TARGET)
        begin
            cfg.src_w = pick_src_dim();
            cfg.src_h = pick_src_dim();
            cfg.view  = 3'($urandom_range(0, 7));
            cfg.scl_w = pick_scale_dim();
            cfg.scl_h = pick_scale_dim();
            apply_cfg(cfg);
            // Hold the receiver off once so the block backs up its input
            if (phase == 5)
                hold_request = 1'b1;
            stream_phase($urandom_range(20, 50));
            drain();
            phase++;
        end

        repeat (END_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.pending_pixels.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
